FILE: src/cdr_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and control structs of the character display refresh engine
package cdr_pkg;

	// screen geometry
	localparam int MAX_ROWS    = 4;
	localparam int MAX_COLS    = 32;
	localparam int SCREEN_SIZE = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W      = (SCREEN_SIZE > 1) ? $clog2(SCREEN_SIZE) : 1;
	localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_W       = $clog2(MAX_COLS + 1);

	// field and register widths
	localparam int OP_W    = 2;
	localparam int ROW_W   = 2;
	localparam int COLF_W  = 5;
	localparam int BYTE_W  = 8;
	localparam int RROWS_W = 3;
	localparam int RCOLS_W = 6;
	localparam int GAP_W   = 5;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register reset values
	localparam logic [RROWS_W-1:0] ROWS_RST = 3'd2;
	localparam logic [RCOLS_W-1:0] COLS_RST = 6'd16;
	localparam logic [GAP_W-1:0]   GAP_RST  = 5'd4;
	localparam logic [GAP_W-1:0]   MIN_GAP  = 5'd2;

	// display bytes
	localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
	localparam logic [BYTE_W-1:0] CMD_HOME   = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_CURSOR = 8'h11;
	localparam logic [BYTE_W-1:0] CMD_CLEAR  = 8'h0C;

	typedef enum logic [OP_W-1:0] {
		OP_PUT,
		OP_SOFT_CLR,
		OP_FULL_CLR,
		OP_FLUSH
	} op_t;

	typedef enum logic [1:0] {
		REG_ROWS,
		REG_COLS,
		REG_GAP
	} reg_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_CLEAR,
		EM_HOME,
		EM_CURSOR,
		EM_COL,
		EM_ROW,
		EM_DATA
	} emit_t;

	typedef struct packed {
		logic [RROWS_W-1:0] rows_used;
		logic [RCOLS_W-1:0] cols_used;
		logic [GAP_W-1:0]   gap_limit;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic  take;
		logic  ld_step;
		logic  scan_init;
		logic  scan_step;
		logic  look_init;
		logic  look_step;
		logic  data_step;
		logic  resume;
		emit_t emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  req_op;
		logic flush_ok;
		logic out_free;
		logic ld_done;
		logic ld_busy;
		logic c_end;
		logic c_diff;
		logic k_end;
		logic k_diff;
		logic eq_over;
		logic home;
		logic data_end;
	} st_t;

endpackage

FILE: src/cdr_in_if.sv
`timescale 1ns / 1ps
// request channel carrying one display operation per word
interface cdr_in_if import cdr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [ROW_W-1:0]  row;
	logic [COLF_W-1:0] col;
	logic [BYTE_W-1:0] char_code;

	modport source (output valid, opcode, row, col, char_code, input ready);
	modport sink   (input valid, opcode, row, col, char_code, output ready);
endinterface

FILE: src/cdr_out_if.sv
`timescale 1ns / 1ps
// byte channel toward the display serial link
interface cdr_out_if import cdr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source (output valid, out_byte, last, input ready);
	modport sink   (input valid, out_byte, last, output ready);
endinterface

FILE: src/char_display_diff_refresh.sv
`timescale 1ns / 1ps
// top level of the character display shadow refresh engine
// put and soft clear leave the sequencer idle: words are accepted back to back
// full clear goes through the clear state and sends one byte once the output register is free
// flush: accept the word, stream the row from both screen rams into the row buffer,
//   then scan and lookahead walk the columns up to the row end and send each run
// reset: registers to rows 2, cols 16, gap 4; both screens read as spaces via valid bits
//   cleared at once by reset, so no clearing pass is needed
module char_display_diff_refresh import cdr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	cdr_in_if.sink             cmd,
	cdr_out_if.source          disp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// configuration as written over apb; saturation happens in the datapath
	cfg_t cfg;

	// controller <-> datapath handshake
	cmd_t ctl_cmd;
	st_t  ctl_st;

	cdr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// sequencer: idle accepts words, flush walks load -> scan -> lookahead -> cursor -> data
	cdr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(cmd.valid),
		.in_ready(cmd.ready),
		.st      (ctl_st),
		.cmd     (ctl_cmd)
	);

	// datapath: pending/shown screen rams, row buffer with diff bits, output register
	cdr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (ctl_cmd),
		.st       (ctl_st),
		.in_opcode(cmd.opcode),
		.in_row   (cmd.row),
		.in_col   (cmd.col),
		.in_char  (cmd.char_code),
		.out_ready(disp.ready),
		.out_valid(disp.valid),
		.out_byte (disp.out_byte),
		.out_last (disp.last)
	);

endmodule

FILE: src/cdr_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module cdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/cdr_regs.sv
`timescale 1ns / 1ps
// apb configuration registers
module cdr_regs import cdr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	reg_t reg_idx;
	logic wr_en;

	assign reg_idx = reg_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.rows_used <= ROWS_RST;
			cfg.cols_used <= COLS_RST;
			cfg.gap_limit <= GAP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ROWS: cfg.rows_used <= pwdata[RROWS_W-1:0];
				REG_COLS: cfg.cols_used <= pwdata[RCOLS_W-1:0];
				REG_GAP:  cfg.gap_limit <= pwdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ROWS: prdata = PDATA_W'(cfg.rows_used);
			REG_COLS: prdata = PDATA_W'(cfg.cols_used);
			REG_GAP:  prdata = PDATA_W'(cfg.gap_limit);
			default:  prdata = '0;
		endcase
	end

endmodule

FILE: src/cdr_ctrl.sv
`timescale 1ns / 1ps
// sequencer for clears, row load, run search and byte emission
module cdr_ctrl import cdr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  st_t  st,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_LOAD,
		S_SCAN,
		S_LOOK,
		S_CMD0,
		S_CMD1,
		S_CMD2,
		S_DATA
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd.take      = 1'b0;
		cmd.ld_step   = 1'b0;
		cmd.scan_init = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.look_init = 1'b0;
		cmd.look_step = 1'b0;
		cmd.data_step = 1'b0;
		cmd.resume    = 1'b0;
		cmd.emit      = EM_NONE;
		in_ready      = 1'b0;
		state_nxt     = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					case (st.req_op)
						OP_FULL_CLR: state_nxt = S_CLEAR;
						OP_FLUSH: begin
							if (st.flush_ok) begin
								state_nxt = S_LOAD;
							end
						end
						default: ;
					endcase
				end
			end
			S_CLEAR: begin
				if (st.out_free) begin
					cmd.emit  = EM_CLEAR;
					state_nxt = S_IDLE;
				end
			end
			S_LOAD: begin
				if (!st.ld_done) begin
					cmd.ld_step = 1'b1;
				end else if (!st.ld_busy) begin
					cmd.scan_init = 1'b1;
					state_nxt     = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.c_end) begin
					state_nxt = S_IDLE;
				end else if (st.c_diff) begin
					cmd.look_init = 1'b1;
					state_nxt     = S_LOOK;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_LOOK: begin
				if (st.k_end) begin
					state_nxt = S_CMD0;
				end else if (st.k_diff || !st.eq_over) begin
					cmd.look_step = 1'b1;
				end else begin
					state_nxt = S_CMD0;
				end
			end
			S_CMD0: begin
				if (st.out_free) begin
					if (st.home) begin
						cmd.emit  = EM_HOME;
						state_nxt = S_DATA;
					end else begin
						cmd.emit  = EM_CURSOR;
						state_nxt = S_CMD1;
					end
				end
			end
			S_CMD1: begin
				if (st.out_free) begin
					cmd.emit  = EM_COL;
					state_nxt = S_CMD2;
				end
			end
			S_CMD2: begin
				if (st.out_free) begin
					cmd.emit  = EM_ROW;
					state_nxt = S_DATA;
				end
			end
			S_DATA: begin
				if (st.out_free) begin
					cmd.emit = EM_DATA;
					if (st.data_end) begin
						cmd.resume = 1'b1;
						state_nxt  = S_SCAN;
					end else begin
						cmd.data_step = 1'b1;
					end
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: src/cdr_dp.sv
`timescale 1ns / 1ps
// screen stores, row buffer, run counters and output register
module cdr_dp import cdr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	output st_t               st,
	input  logic [OP_W-1:0]   in_opcode,
	input  logic [ROW_W-1:0]  in_row,
	input  logic [COLF_W-1:0] in_col,
	input  logic [BYTE_W-1:0] in_char,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last
);

	localparam int EFF_W = 7;

	// effective register values
	logic [EFF_W-1:0] rows_x, cols_x, eff_rows, eff_cols;
	logic [CNT_W-1:0] nc;
	logic [GAP_W-1:0] gap_eff;

	assign rows_x   = EFF_W'(cfg.rows_used);
	assign cols_x   = EFF_W'(cfg.cols_used);
	assign eff_rows = (rows_x == '0) ? EFF_W'(1) :
	                  (rows_x > EFF_W'(MAX_ROWS)) ? EFF_W'(MAX_ROWS) : rows_x;
	assign eff_cols = (cols_x == '0) ? EFF_W'(1) :
	                  (cols_x > EFF_W'(MAX_COLS)) ? EFF_W'(MAX_COLS) : cols_x;
	assign nc       = CNT_W'(eff_cols);
	assign gap_eff  = (cfg.gap_limit < MIN_GAP) ? MIN_GAP : cfg.gap_limit;

	// request decode
	op_t  op;
	logic row_ok, put_ok, do_put, do_soft, do_full, do_flush;

	assign op       = op_t'(in_opcode);
	assign row_ok   = EFF_W'(in_row) < eff_rows;
	assign put_ok   = row_ok && (EFF_W'(in_col) < eff_cols);
	assign do_put   = cmd.take && (op == OP_PUT) && put_ok;
	assign do_soft  = cmd.take && (op == OP_SOFT_CLR);
	assign do_full  = cmd.take && (op == OP_FULL_CLR);
	assign do_flush = cmd.take && (op == OP_FLUSH);

	// state registers
	logic [ROW_W-1:0]       row_q;
	logic [CNT_W-1:0]       ld_q;
	logic                   ld_v_s1;
	logic [COL_W-1:0]       ld_col_s1;
	logic                   pv_s1, sv_s1;
	logic [SCREEN_SIZE-1:0] pvld_q, svld_q;
	logic [BYTE_W-1:0]      pbuf_q [MAX_COLS];
	logic [MAX_COLS-1:0]    diff_q;
	logic [CNT_W-1:0]       c_q, k_q;
	logic [COL_W-1:0]       end_q, b_q;
	logic [GAP_W-1:0]       eq_q;
	logic                   out_v_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   out_last_q;

	// store addressing
	logic [ADDR_W-1:0] put_addr, rd_addr, sw_addr;
	logic [BYTE_W-1:0] pend_rd, shown_rd, pend_val, shown_val;

	assign put_addr  = ADDR_W'(32'(in_row) * MAX_COLS + 32'(in_col));
	assign rd_addr   = ADDR_W'(32'(row_q) * MAX_COLS + 32'(ld_q[COL_W-1:0]));
	assign sw_addr   = ADDR_W'(32'(row_q) * MAX_COLS + 32'(ld_col_s1));
	assign pend_val  = pv_s1 ? pend_rd : SPACE_CHAR;
	assign shown_val = sv_s1 ? shown_rd : SPACE_CHAR;

	cdr_ram #(.WIDTH(BYTE_W), .DEPTH(SCREEN_SIZE)) u_pend (
		.clk  (clk),
		.we   (do_put),
		.waddr(put_addr),
		.wdata(in_char),
		.raddr(rd_addr),
		.rdata(pend_rd)
	);

	// the shown row is overwritten with the pending row as it streams in
	cdr_ram #(.WIDTH(BYTE_W), .DEPTH(SCREEN_SIZE)) u_shown (
		.clk  (clk),
		.we   (ld_v_s1),
		.waddr(sw_addr),
		.wdata(pend_val),
		.raddr(rd_addr),
		.rdata(shown_rd)
	);

	// status
	logic more_diff;

	assign more_diff   = |(diff_q >> k_q);
	assign st.req_op   = op;
	assign st.flush_ok = row_ok;
	assign st.out_free = !out_v_q || out_ready;
	assign st.ld_done  = (ld_q == CNT_W'(MAX_COLS));
	assign st.ld_busy  = ld_v_s1;
	assign st.c_end    = (c_q >= nc);
	assign st.c_diff   = !st.c_end && diff_q[c_q[COL_W-1:0]];
	assign st.k_end    = (k_q >= nc);
	assign st.k_diff   = !st.k_end && diff_q[k_q[COL_W-1:0]];
	assign st.eq_over  = (eq_q >= gap_eff);
	assign st.home     = (row_q == '0) && (c_q == '0);
	assign st.data_end = (b_q == end_q);

	// emitted byte
	logic [BYTE_W-1:0] em_byte;
	logic              em_last;

	always_comb begin
		em_last = 1'b0;
		case (cmd.emit)
			EM_CLEAR: begin
				em_byte = CMD_CLEAR;
				em_last = 1'b1;
			end
			EM_HOME:   em_byte = CMD_HOME;
			EM_CURSOR: em_byte = CMD_CURSOR;
			EM_COL:    em_byte = BYTE_W'(c_q);
			EM_ROW:    em_byte = BYTE_W'(row_q);
			EM_DATA: begin
				em_byte = pbuf_q[b_q];
				em_last = st.data_end && !more_diff;
			end
			default:   em_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q  <= '0;
			svld_q  <= '0;
			ld_q    <= '0;
			ld_v_s1 <= 1'b0;
			c_q     <= '0;
			k_q     <= '0;
			end_q   <= '0;
			b_q     <= '0;
			eq_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (do_soft || do_full) begin
				pvld_q <= '0;
			end else if (do_put) begin
				pvld_q[put_addr] <= 1'b1;
			end
			if (do_full) begin
				svld_q <= '0;
			end else if (ld_v_s1) begin
				svld_q[sw_addr] <= 1'b1;
			end

			if (do_flush) begin
				ld_q <= '0;
			end else if (cmd.ld_step) begin
				ld_q <= ld_q + 1'b1;
			end
			ld_v_s1 <= cmd.ld_step;

			if (cmd.scan_init) begin
				c_q <= '0;
			end else if (cmd.scan_step) begin
				c_q <= c_q + 1'b1;
			end else if (cmd.resume) begin
				c_q <= k_q;
			end

			if (cmd.look_init) begin
				k_q   <= c_q + 1'b1;
				end_q <= c_q[COL_W-1:0];
				b_q   <= c_q[COL_W-1:0];
				eq_q  <= '0;
			end else if (cmd.look_step) begin
				k_q <= k_q + 1'b1;
				if (st.k_diff) begin
					end_q <= k_q[COL_W-1:0];
					eq_q  <= '0;
				end else begin
					eq_q <= eq_q + 1'b1;
				end
			end else if (cmd.data_step) begin
				b_q <= b_q + 1'b1;
			end

			if (cmd.emit != EM_NONE) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_flush) begin
			row_q <= in_row;
		end
		if (cmd.ld_step) begin
			ld_col_s1 <= ld_q[COL_W-1:0];
			pv_s1     <= pvld_q[rd_addr];
			sv_s1     <= svld_q[rd_addr];
		end
		if (ld_v_s1) begin
			pbuf_q[ld_col_s1] <= pend_val;
			diff_q[ld_col_s1] <= (CNT_W'(ld_col_s1) < nc) && (pend_val != shown_val);
		end
		if (cmd.emit != EM_NONE) begin
			out_byte_q <= em_byte;
			out_last_q <= em_last;
		end
	end

	assign out_valid = out_v_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EM_NONE) |-> (!out_v_q || out_ready))
		else $error("byte emitted into an occupied output register");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit == EM_DATA) |-> (b_q <= end_q))
		else $error("data byte beyond the end of its run");

	a_gap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.look_step |-> (st.k_diff || (eq_q < gap_eff)))
		else $error("run absorbed more equal bytes than the gap allows");

	a_load_copy: assert property (@(posedge clk) disable iff (!arst_n)
		ld_v_s1 |-> (cmd.emit == EM_NONE))
		else $error("byte emitted while the row is still loading");

endmodule

FILE: tb/char_display_diff_refresh_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the character display refresh engine with a shadow-screen predictor
module char_display_diff_refresh_tb;
	import cdr_pkg::*;

	// cycles to let a flush that sends nothing run out before a register write
	localparam int SCAN_SETTLE  = 3 * MAX_COLS + 60;
	// cycles with no accepted word, no sent byte and no register write before giving up
	localparam int QUIET_LIMIT  = 4000;
	// register index that decodes to nothing
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		logic [BYTE_W-1:0] b;
		logic              last;
	} disp_byte_t;

	logic clk;
	logic arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	cdr_in_if  cmd_ch ();
	cdr_out_if disp_ch ();

	char_display_diff_refresh i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.disp    (disp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow copy of both screens and of the registers as written
	logic [BYTE_W-1:0]  pend_scr  [SCREEN_SIZE];
	logic [BYTE_W-1:0]  shown_scr [SCREEN_SIZE];
	logic [RROWS_W-1:0] rows_reg;
	logic [RCOLS_W-1:0] cols_reg;
	logic [GAP_W-1:0]   gap_reg;

	// bytes the display link still owes us, oldest first
	disp_byte_t expected_bytes [$];
	int unsigned fail_count;

	// sender burst state
	int unsigned burst_left;

	// receiver stall pattern state
	int unsigned ready_hold;
	logic        ready_jitter;

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// shadow screen predictor
	// ---------------------------------------------------------------

	function automatic void reset_shadow();
		for (int i = 0; i < SCREEN_SIZE; i++) begin
			pend_scr[i]  = SPACE_CHAR;
			shown_scr[i] = SPACE_CHAR;
		end
		rows_reg = ROWS_RST;
		cols_reg = COLS_RST;
		gap_reg  = GAP_RST;
	endfunction

	// register values clamp into the legal geometry when used, not when written
	function automatic int used_rows();
		if (rows_reg < 1) return 1;
		if (rows_reg > MAX_ROWS) return MAX_ROWS;
		return int'(rows_reg);
	endfunction

	function automatic int used_cols();
		if (cols_reg < 1) return 1;
		if (cols_reg > MAX_COLS) return MAX_COLS;
		return int'(cols_reg);
	endfunction

	// a gap limit below the minimum acts as the minimum
	function automatic int run_gap();
		if (gap_reg < MIN_GAP) return int'(MIN_GAP);
		return int'(gap_reg);
	endfunction

	function automatic void add_byte(input logic [BYTE_W-1:0] b);
		disp_byte_t e;
		e.b    = b;
		e.last = 1'b0;
		expected_bytes.push_back(e);
	endfunction

	// walk one row, one cursor or home command plus the bytes of each run, then mirror the row
	function automatic void flush_prediction(input logic [ROW_W-1:0] r);
		int nc;
		int gap;
		int base;
		int c;
		int k;
		int eq;
		int run_end;
		int first;
		nc    = used_cols();
		gap   = run_gap();
		base  = r * MAX_COLS;
		c     = 0;
		first = expected_bytes.size();
		while (c < nc) begin
			if (pend_scr[base + c] == shown_scr[base + c]) begin
				c++;
				continue;
			end
			// home is the short form of a cursor move to the top left corner
			if (r == 0 && c == 0) begin
				add_byte(CMD_HOME);
			end else begin
				add_byte(CMD_CURSOR);
				add_byte(BYTE_W'(c));
				add_byte(BYTE_W'(r));
			end
			run_end = c;
			eq      = 0;
			// a run swallows equal bytes until one more would exceed the gap limit
			for (k = c + 1; k < nc; k++) begin
				if (pend_scr[base + k] == shown_scr[base + k]) begin
					eq++;
					if (eq > gap) break;
				end else begin
					run_end = k;
					eq      = 0;
				end
			end
			for (int j = c; j <= run_end; j++) add_byte(pend_scr[base + j]);
			c = k;
		end
		for (int j = 0; j < MAX_COLS; j++) shown_scr[base + j] = pend_scr[base + j];
		if (expected_bytes.size() > first) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
	endfunction

	function automatic void predict_word(input op_t op, input logic [ROW_W-1:0] r,
			input logic [COLF_W-1:0] c, input logic [BYTE_W-1:0] ch);
		disp_byte_t e;
		case (op)
			OP_PUT: begin
				// writes outside the used area are dropped
				if (r < used_rows() && c < used_cols()) pend_scr[r * MAX_COLS + c] = ch;
			end
			OP_SOFT_CLR: begin
				for (int i = 0; i < SCREEN_SIZE; i++) pend_scr[i] = SPACE_CHAR;
			end
			OP_FULL_CLR: begin
				// both screens, whole store, regardless of the used area
				for (int i = 0; i < SCREEN_SIZE; i++) begin
					pend_scr[i]  = SPACE_CHAR;
					shown_scr[i] = SPACE_CHAR;
				end
				e.b    = CMD_CLEAR;
				e.last = 1'b1;
				expected_bytes.push_back(e);
			end
			default: begin
				if (r < used_rows()) flush_prediction(r);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// one word on the request channel; valid gets one assignment per step
	task automatic send_word(input op_t op, input logic [ROW_W-1:0] r,
			input logic [COLF_W-1:0] c, input logic [BYTE_W-1:0] ch);
		int unsigned gap_len;
		if (burst_left == 0) begin
			// idle gap, mostly short, sometimes long
			gap_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
			cmd_ch.valid <= 1'b0;
			repeat (gap_len) @(posedge clk);
			// some bursts are long enough to give stretches with no idling
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.opcode    <= op;
		cmd_ch.row       <= r;
		cmd_ch.col       <= c;
		cmd_ch.char_code <= ch;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		burst_left--;
		predict_word(op, r, c, ch);
	endtask

	// apb write: setup cycle, then access cycle held until pready
	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx) << 2;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ROWS: rows_reg = data[RROWS_W-1:0];
			REG_COLS: cols_reg = data[RCOLS_W-1:0];
			REG_GAP:  gap_reg  = data[GAP_W-1:0];
			default: ;
		endcase
		// keep the next write's psel assignment in a step of its own
		@(posedge clk);
	endtask

	// stop sending, collect every owed byte, then let a silent flush finish
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SCAN_SETTLE) @(posedge clk);
	endtask

	task automatic set_geometry(input logic [PDATA_W-1:0] rows_v, input logic [PDATA_W-1:0] cols_v,
			input logic [PDATA_W-1:0] gap_v);
		write_reg(REG_ROWS, rows_v);
		write_reg(REG_COLS, cols_v);
		write_reg(REG_GAP, gap_v);
	endtask

	// ---------------------------------------------------------------
	// random traffic
	// ---------------------------------------------------------------

	// spaces and already-shown bytes make equal cells, so runs and gaps show up
	function automatic logic [BYTE_W-1:0] pick_char(input logic [ROW_W-1:0] r,
			input logic [COLF_W-1:0] c);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 3) return SPACE_CHAR;
		if (sel < 5) return shown_scr[r * MAX_COLS + c];
		if (sel == 5) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// mostly puts into the used area followed by flushes, plus clears and stray words
	task automatic random_words(input int count);
		int unsigned sel;
		logic [ROW_W-1:0]  r;
		logic [COLF_W-1:0] c;
		logic [BYTE_W-1:0] ch;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			r   = ROW_W'($urandom_range(0, 3));
			c   = COLF_W'($urandom_range(0, 31));
			ch  = BYTE_W'($urandom_range(0, 255));
			if (sel < 62) begin
				if ($urandom_range(0, 9) != 0) begin
					r = ROW_W'($urandom_range(0, used_rows() - 1));
					c = COLF_W'($urandom_range(0, used_cols() - 1));
				end
				send_word(OP_PUT, r, c, pick_char(r, c));
			end else if (sel < 88) begin
				if ($urandom_range(0, 9) != 0) r = ROW_W'($urandom_range(0, used_rows() - 1));
				send_word(OP_FLUSH, r, c, ch);
			end else if (sel < 95) begin
				send_word(OP_SOFT_CLR, r, c, ch);
			end else begin
				send_word(OP_FULL_CLR, r, c, ch);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset geometry: home vs cursor, run gaps, ignored words, both clears
	task automatic test_directed();
		send_word(OP_FLUSH, 2'd0, 5'd0, 8'h00);      // nothing changed yet
		send_word(OP_PUT, 2'd0, 5'd0, 8'h00);
		send_word(OP_PUT, 2'd0, 5'd1, 8'hFF);
		send_word(OP_PUT, 2'd0, 5'd15, 8'h41);       // last used column
		send_word(OP_PUT, 2'd0, 5'd16, 8'h42);       // column out of use
		send_word(OP_PUT, 2'd2, 5'd0, 8'h43);        // row out of use
		send_word(OP_PUT, 2'd3, 5'd31, 8'hFF);       // both out of use
		send_word(OP_FLUSH, 2'd0, 5'd31, 8'hFF);     // home run, then a cursor run
		send_word(OP_FLUSH, 2'd0, 5'd0, 8'h00);      // already mirrored
		send_word(OP_PUT, 2'd1, 5'd3, 8'h78);
		send_word(OP_PUT, 2'd1, 5'd5, 8'h79);
		send_word(OP_PUT, 2'd1, 5'd9, 8'h77);
		send_word(OP_FLUSH, 2'd1, 5'd0, 8'h00);      // equal bytes absorbed inside one run
		send_word(OP_FLUSH, 2'd3, 5'd0, 8'h00);      // flush of a row out of use
		send_word(OP_PUT, 2'd0, 5'd2, 8'h7A);
		send_word(OP_SOFT_CLR, 2'd3, 5'd31, 8'hFF);
		send_word(OP_FLUSH, 2'd0, 5'd0, 8'h00);      // spaces go out where text was
		send_word(OP_PUT, 2'd1, 5'd0, 8'h71);
		send_word(OP_FULL_CLR, 2'd0, 5'd0, 8'h00);
		send_word(OP_FLUSH, 2'd1, 5'd0, 8'h00);      // nothing left after the full clear
		send_word(OP_PUT, 2'd1, 5'd1, SPACE_CHAR);   // same as shown
		send_word(OP_FLUSH, 2'd1, 5'd0, 8'h00);
		settle();
	endtask

	// extremes of every register, values that clamp, and a write to an unused index
	task automatic test_register_extremes();
		logic [PDATA_W-1:0] rows_v [7] = '{1, 4, 0, 7, 32'hFFFF_FFFC, 4, 3};
		logic [PDATA_W-1:0] cols_v [7] = '{1, 32, 0, 63, 33, 32, 17};
		logic [PDATA_W-1:0] gap_v  [7] = '{0, 31, 1, 2, 31, 0, 3};
		for (int p = 0; p < 7; p++) begin
			set_geometry(rows_v[p], cols_v[p], gap_v[p]);
			if (p == 1) write_reg(REG_UNUSED, 32'h0000_0001);
			// widest row in the bottom corner before the random part
			if (p == 1) begin
				send_word(OP_PUT, 2'd3, 5'd31, 8'hFF);
				send_word(OP_PUT, 2'd3, 5'd0, 8'h00);
				send_word(OP_FLUSH, 2'd3, 5'd0, 8'h00);
			end
			random_words(25);
			settle();
		end
	endtask

	// random geometry per phase, long mixed traffic
	task automatic test_random_traffic();
		for (int p = 0; p < 4; p++) begin
			set_geometry(PDATA_W'($urandom_range(0, 7)), PDATA_W'($urandom_range(0, 63)),
				PDATA_W'($urandom_range(0, 31)));
			random_words(45);
			settle();
		end
	endtask

	// ---------------------------------------------------------------
	// receiver: stall pattern and byte check
	// ---------------------------------------------------------------

	// segments of steady ready, steady stall, or per-cycle jitter
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			case ($urandom_range(0, 3))
				0: begin
					disp_ch.ready <= 1'b0;
					ready_jitter  <= 1'b0;
					ready_hold    <= $urandom_range(1, 10);
				end
				1: begin
					disp_ch.ready <= 1'b1;
					ready_jitter  <= 1'b1;
					ready_hold    <= $urandom_range(5, 20);
				end
				default: begin
					disp_ch.ready <= 1'b1;
					ready_jitter  <= 1'b0;
					ready_hold    <= $urandom_range(1, 30);
				end
			endcase
		end else begin
			if (ready_jitter) disp_ch.ready <= ($urandom_range(0, 1) != 0);
			ready_hold <= ready_hold - 1;
		end
	end

	// each sent byte against the oldest owed byte
	always @(posedge clk) begin : byte_check
		disp_byte_t want;
		if (arst_n && disp_ch.valid && disp_ch.ready) begin
			if (expected_bytes.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected byte %02h last %0b", disp_ch.out_byte, disp_ch.last);
			end else begin
				want = expected_bytes.pop_front();
				if (disp_ch.out_byte !== want.b || disp_ch.last !== want.last) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
							want.b, want.last, disp_ch.out_byte, disp_ch.last);
				end
			end
		end
	end

	// watchdog on cycles where nothing moves on any port
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (disp_ch.valid && disp_ch.ready) ||
					(psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("char_display_diff_refresh_tb failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.opcode    = OP_PUT;
		cmd_ch.row       = '0;
		cmd_ch.col       = '0;
		cmd_ch.char_code = '0;
		disp_ch.ready    = 1'b0;
		ready_hold       = 0;
		ready_jitter     = 1'b0;
		burst_left       = 0;
		fail_count       = 0;
		reset_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_register_extremes();
		test_random_traffic();
		settle();

		if (fail_count == 0 && expected_bytes.size() == 0) begin
			$display("char_display_diff_refresh_tb passed");
		end else begin
			$display("char_display_diff_refresh_tb failed");
		end
		$finish;
	end

endmodule

FILE: char_display_diff_refresh.f
src/cdr_pkg.sv
src/cdr_in_if.sv
src/cdr_out_if.sv
src/cdr_ram.sv
src/cdr_regs.sv
src/cdr_ctrl.sv
src/cdr_dp.sv
src/char_display_diff_refresh.sv
tb/char_display_diff_refresh_tb.sv
